FILE: design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Field widths, codes and the command and status groups shared by the
// controller and the datapath.
// ----------------------------------------------------------------------------
package lpht_pkg;

   localparam int KEY_W     = 31;
   localparam int VALUE_W   = 32;
   localparam int SIZE_W    = 5;
   localparam int SIZE_MAX  = 31;
   localparam int SIZE_RST  = 11;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int BITCNT_W  = $clog2(KEY_W);
   localparam int ENTRY_W   = KEY_W + VALUE_W;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_PLACED   = 3'd0,
      ST_EXISTS   = 3'd1,
      ST_FULL     = 3'd2,
      ST_REMOVED  = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef struct packed {
      logic capture;
      logic div_step;
      logic probe_init;
      logic probe_check;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic probe_done;
      logic out_free;
   } dp_status_type;

endpackage

FILE: design/lpht_if.sv
// ----------------------------------------------------------------------------
// Linear probe hash table channels
// Valid/ready channels for request items and response items.
// ----------------------------------------------------------------------------
interface lpht_req_if;
   logic                               valid;
   logic                               ready;
   logic                               cmd;
   logic [lpht_pkg::KEY_W-1:0]         key;
   logic signed [lpht_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output key, output value, input ready);
   modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

interface lpht_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lpht_pkg::STATUS_W-1:0]   status;
   logic [lpht_pkg::SLOT_W-1:0]     slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

FILE: design/linear_probe_hash_table.sv
// A request is accepted only in the idle state. The bit-serial remainder of
// the key gives the home slot; each of the P slots probed (1 to the table size)
// then takes one RAM read. No new item is accepted until the last one is
// finished; a waiting response stalls only the finish step of the following
// item until it is taken.
// Reset clears every slot to empty and sets the table size to 11.
// ----------------------------------------------------------------------------
// Linear probe hash table
// Open addressing hash table with insert and delete over linear probe chains,
// tombstones on delete and a full-table status.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [lpht_pkg::SIZE_W-1:0]   csr_wdata,
   lpht_req_if.sink                      req_ch,
   lpht_rsp_if.source                    rsp_ch
);

   lpht_pkg::dp_cmd_type    dp_cmd;
   lpht_pkg::dp_status_type dp_status;
   logic                    req_ready;

   lpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   lpht_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_cmd    (req_ch.cmd),
      .req_key    (req_ch.key),
      .req_value  (req_ch.value),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_status (rsp_ch.status),
      .rsp_slot   (rsp_ch.slot)
   );

   assign req_ch.ready = req_ready;

endmodule

FILE: design/lpht_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences request capture, the home slot division, the probe loop and the
// hand-off of each result to the response register.
// ----------------------------------------------------------------------------
module lpht_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lpht_pkg::dp_status_type dp_status,
   output lpht_pkg::dp_cmd_type    dp_cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DIV    = 6'b000010,
      S_INIT   = 6'b000100,
      S_READ   = 6'b001000,
      S_CHECK  = 6'b010000,
      S_FINISH = 6'b100000
   } fsm_type;

   fsm_type state_ff;
   fsm_type state_in;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (dp_status.div_done) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            dp_cmd.probe_init = 1'b1;
            state_in          = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            dp_cmd.probe_check = 1'b1;
            state_in = dp_status.probe_done ? S_FINISH : S_READ;
         end
         S_FINISH: begin
            if (dp_status.out_free) begin
               dp_cmd.finish = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

FILE: design/lpht_dp.sv
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Size register, bit-serial remainder unit, slot state flags, key and value
// RAM, probe registers and the response output register.
// ----------------------------------------------------------------------------
module lpht_dp #(
   parameter int MAX_SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [lpht_pkg::SIZE_W-1:0]          csr_wdata,
   input  logic                                 req_cmd,
   input  logic [lpht_pkg::KEY_W-1:0]           req_key,
   input  logic signed [lpht_pkg::VALUE_W-1:0]  req_value,
   input  lpht_pkg::dp_cmd_type                 dp_cmd,
   output lpht_pkg::dp_status_type              dp_status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lpht_pkg::STATUS_W-1:0]        rsp_status,
   output logic [lpht_pkg::SLOT_W-1:0]          rsp_slot
);

   localparam int ADDR_W      = $clog2(MAX_SLOTS);
   localparam int EFF_LIMIT   = (MAX_SLOTS < lpht_pkg::SIZE_MAX) ? MAX_SLOTS
                                                                 : lpht_pkg::SIZE_MAX;
   localparam int STATE_DEPTH = EFF_LIMIT;
   localparam int SADDR_W     = (STATE_DEPTH > 1) ? $clog2(STATE_DEPTH) : 1;
   localparam int SIZE_W      = lpht_pkg::SIZE_W;
   localparam int KEY_W       = lpht_pkg::KEY_W;
   localparam int VALUE_W     = lpht_pkg::VALUE_W;
   localparam int SLOT_W      = lpht_pkg::SLOT_W;
   localparam int BITCNT_W    = lpht_pkg::BITCNT_W;

   logic [SIZE_W-1:0]               size_ff;
   logic [SIZE_W-1:0]               eff_size;

   lpht_pkg::cmd_type               cmd_ff, cmd_in;
   logic [KEY_W-1:0]                key_ff, key_in;
   logic signed [VALUE_W-1:0]       value_ff, value_in;
   logic [KEY_W-1:0]                shift_ff, shift_in;
   logic [SIZE_W-1:0]               rem_ff, rem_in;
   logic [BITCNT_W-1:0]             bitcnt_ff, bitcnt_in;
   logic [SIZE_W-1:0]               idx_ff, idx_in;
   logic [SIZE_W-1:0]               cnt_ff, cnt_in;
   logic                            have_ff, have_in;
   logic [SIZE_W-1:0]               free_ff, free_in;
   lpht_pkg::status_type            status_ff, status_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   lpht_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]               rsp_slot_ff, rsp_slot_in;

   lpht_pkg::slot_state_type        slot_state_ff [STATE_DEPTH];
   logic                            state_we;
   logic [SADDR_W-1:0]              state_waddr;
   lpht_pkg::slot_state_type        state_wdata;

   logic [SIZE_W:0]                 trial;
   lpht_pkg::slot_state_type        cur_state;
   logic [lpht_pkg::ENTRY_W-1:0]    ram_rd_data;
   logic                            hit;
   logic                            place;
   logic [SIZE_W-1:0]               idx_inc;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(lpht_pkg::SIZE_RST);
      end else if (csr_we) begin
         size_ff <= csr_wdata;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         eff_size = SIZE_W'(1);
      end else if (size_ff > SIZE_W'(EFF_LIMIT)) begin
         eff_size = SIZE_W'(EFF_LIMIT);
      end else begin
         eff_size = size_ff;
      end
   end

   assign trial     = {rem_ff, shift_ff[KEY_W-1]};
   assign cur_state = slot_state_ff[SADDR_W'(idx_ff)];
   assign hit       = (cur_state == lpht_pkg::SLOT_USED)
                      && (ram_rd_data[KEY_W-1:0] == key_ff);
   assign place     = (cmd_ff == lpht_pkg::CMD_INSERT)
                      && (status_ff == lpht_pkg::ST_FULL) && have_ff;
   assign idx_inc   = idx_ff + SIZE_W'(1);

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      bitcnt_in     = bitcnt_ff;
      idx_in        = idx_ff;
      cnt_in        = cnt_ff;
      have_in       = have_ff;
      free_in       = free_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      state_we      = 1'b0;
      state_waddr   = SADDR_W'(idx_ff);
      state_wdata   = lpht_pkg::SLOT_TOMB;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (dp_cmd.capture) begin
         cmd_in    = lpht_pkg::cmd_type'(req_cmd);
         key_in    = req_key;
         value_in  = req_value;
         shift_in  = req_key;
         rem_in    = '0;
         bitcnt_in = BITCNT_W'(KEY_W - 1);
      end

      if (dp_cmd.div_step) begin
         if (trial >= {1'b0, eff_size}) begin
            rem_in = SIZE_W'(trial - {1'b0, eff_size});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         shift_in  = {shift_ff[KEY_W-2:0], 1'b0};
         bitcnt_in = bitcnt_ff - BITCNT_W'(1);
      end

      if (dp_cmd.probe_init) begin
         idx_in    = rem_ff;
         cnt_in    = '0;
         have_in   = 1'b0;
         free_in   = '0;
         status_in = (cmd_ff == lpht_pkg::CMD_DELETE) ? lpht_pkg::ST_NOTFOUND
                                                      : lpht_pkg::ST_FULL;
      end

      if (dp_cmd.probe_check) begin
         if (cur_state == lpht_pkg::SLOT_EMPTY) begin
            if (!have_ff) begin
               have_in = 1'b1;
               free_in = idx_ff;
            end
         end else if (hit) begin
            have_in = 1'b0;
            if (cmd_ff == lpht_pkg::CMD_DELETE) begin
               status_in = lpht_pkg::ST_REMOVED;
               state_we  = 1'b1;
            end else begin
               status_in = lpht_pkg::ST_EXISTS;
            end
         end else begin
            if ((cur_state != lpht_pkg::SLOT_USED) && !have_ff) begin
               have_in = 1'b1;
               free_in = idx_ff;
            end
            idx_in = (idx_inc == eff_size) ? '0 : idx_inc;
            cnt_in = cnt_ff + SIZE_W'(1);
         end
      end

      if (dp_cmd.finish) begin
         rsp_valid_in = 1'b1;
         if (place) begin
            rsp_status_in = lpht_pkg::ST_PLACED;
            rsp_slot_in   = free_ff[SLOT_W-1:0];
            state_we      = 1'b1;
            state_waddr   = SADDR_W'(free_ff);
            state_wdata   = lpht_pkg::SLOT_USED;
         end else begin
            rsp_status_in = status_ff;
            rsp_slot_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STATE_DEPTH; i++) begin
            slot_state_ff[i] <= lpht_pkg::SLOT_EMPTY;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (state_we) begin
            slot_state_ff[state_waddr] <= state_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      shift_ff      <= shift_in;
      rem_ff        <= rem_in;
      bitcnt_ff     <= bitcnt_in;
      idx_ff        <= idx_in;
      cnt_ff        <= cnt_in;
      have_ff       <= have_in;
      free_ff       <= free_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   lpht_ram #(
      .WIDTH (lpht_pkg::ENTRY_W),
      .DEPTH (MAX_SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (dp_cmd.finish && place),
      .wr_addr (ADDR_W'(free_ff)),
      .wr_data ({value_ff, key_ff}),
      .rd_addr (ADDR_W'(idx_ff)),
      .rd_data (ram_rd_data)
   );

   assign dp_status.div_done   = (bitcnt_ff == '0);
   assign dp_status.probe_done = (cur_state == lpht_pkg::SLOT_EMPTY) || hit
                                 || (cnt_ff == (eff_size - SIZE_W'(1)));
   assign dp_status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;

endmodule
